### hw/rtl/ida_pkg.sv
// Shared constants, state types and handoff struct for the decimal ASCII converter.
`timescale 1ns / 1ps

package ida_pkg;

    // Default width of the signed input value
    localparam int VALUE_WIDTH_DEF = 32;

    // Character codes
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    // Binary-to-BCD converter states
    typedef enum logic [1:0] {
        D_IDLE,
        D_SHIFT,
        D_HOLD
    } dab_state_t;

    // Character emitter states
    typedef enum logic [1:0] {
        E_IDLE,
        E_SIGN,
        E_SKIP,
        E_SEND
    } emit_state_t;

    // Handoff from converter to emitter; the BCD digits travel beside it
    typedef struct packed {
        logic valid;
        logic negative;
    } ida_hand_t;

endpackage

### hw/rtl/int_to_decimal_ascii.sv
// Top level of the signed binary to decimal ASCII text converter.
`timescale 1ns / 1ps

// Converts one signed VALUE_WIDTH-bit two's complement integer per input
// transaction into its decimal text, one ASCII character per output
// transaction: a '-' first for negative values, then the digits most
// significant first with leading zeros dropped, zero giving a single '0'.
// m_axis_tlast marks the final character of each number. The most negative
// value converts exactly ("-2147483648" at the default width). Input bits
// above VALUE_WIDTH are ignored. The bit-serial shift-and-add-3 converter
// loads a value, runs VALUE_WIDTH shift steps and then hands over its
// digits. The character emitter then takes the digits, drops each
// suppressed leading zero, moves from skipping to sending, and sends each
// character (sign included) while the output is taken. The converter accepts
// the next value as soon as it has handed its digits to the emitter, so the
// two overlap and a steady stream runs at the slower of the two.
module int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = ida_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Input stream
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,  // [VALUE_WIDTH-1:0] value
    // Output stream
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [7:0]                              m_axis_tdata,  // [7:0] ascii_char
    output logic                                    m_axis_tlast   // last
);

    // Decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1):
    // floor((VALUE_WIDTH-1) * log10(2)) + 1, with log10(2) ~ 1233 / 4096
    localparam int NDIG = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;

    ida_pkg::ida_hand_t      hand;
    logic [NDIG*4-1:0]       bcd;
    logic                    hand_ready;

    // Binary to BCD, one magnitude bit per cycle
    ida_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NDIG        (NDIG)
    ) u_dabble (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (s_axis_tvalid),
        .value      (s_axis_tdata[VALUE_WIDTH-1:0]),
        .ready      (s_axis_tready),
        .hand       (hand),
        .bcd        (bcd),
        .hand_ready (hand_ready)
    );

    // Sign and digits out as characters behind a register, one per cycle while sending and the output is taken
    ida_emit #(
        .NDIG (NDIG)
    ) u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .hand          (hand),
        .bcd           (bcd),
        .hand_ready    (hand_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### hw/rtl/ida_dabble.sv
// Bit-serial shift-and-add-3 converter from a signed binary value to packed BCD.
`timescale 1ns / 1ps

module ida_dabble #(
    parameter int VALUE_WIDTH = ida_pkg::VALUE_WIDTH_DEF,
    parameter int NDIG        = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [VALUE_WIDTH-1:0]   value,
    output logic                     ready,
    output ida_pkg::ida_hand_t       hand,
    output logic [NDIG*4-1:0]        bcd,
    input  logic                     hand_ready
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);
    localparam int BCD_W = NDIG * 4;

    ida_pkg::dab_state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [CNT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic                   neg_reg, neg_next;
    logic [BCD_W-1:0]       bcd_adj;
    logic                   shift_en;
    logic                   load_en;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ida_pkg::D_IDLE:
            begin
                if (start)
                    state_next = ida_pkg::D_SHIFT;
            end
            ida_pkg::D_SHIFT:
            begin
                if (bit_cnt_reg == '0)
                    state_next = ida_pkg::D_HOLD;
            end
            ida_pkg::D_HOLD:
            begin
                if (hand_ready)
                    state_next = ida_pkg::D_IDLE;
            end
            default:
            begin
                state_next = ida_pkg::D_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        ready         = 1'b0;
        shift_en      = 1'b0;
        hand.valid    = 1'b0;
        hand.negative = neg_reg;
        case (state_reg)
            ida_pkg::D_IDLE:  ready      = 1'b1;
            ida_pkg::D_SHIFT: shift_en   = 1'b1;
            ida_pkg::D_HOLD:  hand.valid = 1'b1;
            default:          ready      = 1'b0;
        endcase
    end

    assign load_en = ready && start;
    assign bcd     = bcd_reg;

    // Add 3 to every digit of 5 or more, then shift in the next magnitude bit
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        neg_next     = neg_reg;
        if (load_en)
        begin
            neg_next     = value[VALUE_WIDTH-1];
            // The most negative value maps onto its own unsigned magnitude
            bin_next     = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
            bcd_next     = '0;
            bit_cnt_next = CNT_W'(VALUE_WIDTH - 1);
        end
        else if (shift_en)
        begin
            bcd_next     = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_next     = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ida_pkg::D_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        neg_reg     <= neg_next;
    end

    // All magnitude bits have been shifted out once the digits are handed over
    a_hold_bin_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ida_pkg::D_HOLD |-> bin_reg == '0)
        else $error("magnitude bits left over at handoff");

    // The last shift step leads straight to the handoff
    a_shift_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ida_pkg::D_SHIFT && bit_cnt_reg == '0) |=>
            state_reg == ida_pkg::D_HOLD)
        else $error("converter missed end of shift pass");

    // A load always starts a fresh BCD accumulator
    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        load_en |=> (state_reg == ida_pkg::D_SHIFT && bcd_reg == '0))
        else $error("BCD accumulator not cleared on load");

endmodule

### hw/rtl/ida_emit.sv
// Serializes a sign and packed BCD digits into ASCII characters behind an output register.
`timescale 1ns / 1ps

module ida_emit #(
    parameter int NDIG = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ida_pkg::ida_hand_t   hand,
    input  logic [NDIG*4-1:0]    bcd,
    output logic                 hand_ready,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,
    output logic                 m_axis_tlast
);

    localparam int CNT_W = $clog2(NDIG + 1);
    localparam int BCD_W = NDIG * 4;

    ida_pkg::emit_state_t state_reg, state_next;

    logic [BCD_W-1:0] digits_reg, digits_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic             out_last_reg, out_last_next;

    logic [3:0] top_digit;
    logic       out_free;
    logic       leading_zero;
    logic       emit_sign;
    logic       emit_digit;
    logic       skip_zero;

    assign top_digit    = digits_reg[BCD_W-1 -: 4];
    assign out_free     = !out_valid_reg || m_axis_tready;
    assign leading_zero = (top_digit == 4'd0) && (cnt_reg > CNT_W'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ida_pkg::E_IDLE:
            begin
                if (hand.valid)
                    state_next = hand.negative ? ida_pkg::E_SIGN : ida_pkg::E_SKIP;
            end
            ida_pkg::E_SIGN:
            begin
                if (out_free)
                    state_next = ida_pkg::E_SKIP;
            end
            ida_pkg::E_SKIP:
            begin
                if (!leading_zero)
                    state_next = ida_pkg::E_SEND;
            end
            ida_pkg::E_SEND:
            begin
                if (out_free && cnt_reg == CNT_W'(1))
                    state_next = ida_pkg::E_IDLE;
            end
            default:
            begin
                state_next = ida_pkg::E_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        hand_ready = 1'b0;
        emit_sign  = 1'b0;
        skip_zero  = 1'b0;
        emit_digit = 1'b0;
        case (state_reg)
            ida_pkg::E_IDLE: hand_ready = 1'b1;
            ida_pkg::E_SIGN: emit_sign  = out_free;
            ida_pkg::E_SKIP: skip_zero  = leading_zero;
            ida_pkg::E_SEND: emit_digit = out_free;
            default:         hand_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        digits_next    = digits_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (hand_ready && hand.valid)
        begin
            digits_next = bcd;
            cnt_next    = CNT_W'(NDIG);
        end
        if (emit_sign)
        begin
            out_valid_next = 1'b1;
            out_char_next  = ida_pkg::ASCII_MINUS;
            out_last_next  = 1'b0;
        end
        // Advance one digit, whether it is dropped or sent
        if (skip_zero || emit_digit)
        begin
            digits_next = {digits_reg[BCD_W-5:0], 4'b0000};
            cnt_next    = cnt_reg - CNT_W'(1);
        end
        if (emit_digit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = ida_pkg::ASCII_ZERO + {4'b0000, top_digit};
            out_last_next  = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ida_pkg::E_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg   <= digits_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;

    // Digits left to walk never run out before the run ends
    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ida_pkg::E_IDLE && state_reg != ida_pkg::E_SIGN |-> cnt_reg != '0)
        else $error("digit count exhausted mid-run");

    // Sending the final digit closes the run
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_digit && cnt_reg == CNT_W'(1)) |=> (state_reg == ida_pkg::E_IDLE && m_axis_tlast))
        else $error("run not closed after final digit");

    // Every sent digit is a valid decimal digit
    a_bcd_digit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ida_pkg::E_SEND |-> top_digit <= 4'd9)
        else $error("non-decimal BCD digit");

endmodule

### verif/tb_int_to_decimal_ascii.sv
// Testbench for the signed binary to decimal ASCII converter: stream stimulus and text scoreboard.
`timescale 1ns / 1ps

module tb_int_to_decimal_ascii;

    localparam int VW          = ida_pkg::VALUE_WIDTH_DEF;
    localparam int TDW         = ((VW + 7) / 8) * 8;
    localparam int RADIX       = 10;
    localparam int RANDOM_ITEMS = 100;
    localparam int IDLE_PCT    = 24;
    // Cycles with no transaction on either side before the run is declared hung.
    // One value needs a full conversion pass plus up to eleven characters, each of
    // which may wait out a run of receiver stalls; this is many times that.
    localparam int STALL_LIMIT = 4000;
    // Drain time after the last expected character: covers a full conversion pass
    // in case a stray character is still on its way.
    localparam int TAIL_CYCLES = 4 * (VW + 2);
    localparam int REPORT_MAX  = 10;

    // One expected output transaction: a character and its end-of-number flag
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    // Expected decimal text of every accepted value, oldest first
    class decimal_text_board;
        text_char_t pending_chars[$];
        int         values_seen;
        int         chars_checked;
        int         mismatches;

        function new();
            values_seen   = 0;
            chars_checked = 0;
            mismatches    = 0;
        endfunction

        // Expand one accepted value into its expected characters
        function void note_value(logic [VW-1:0] raw);
            logic           neg;
            logic [VW-1:0]  mag;
            logic [7:0]     digits[$];
            text_char_t     c;
            neg = raw[VW-1];
            // Unsigned magnitude, so the most negative value comes out exact
            mag = neg ? (~raw + 1'b1) : raw;
            do
            begin
                digits.push_front(ida_pkg::ASCII_ZERO + 8'(mag % RADIX));
                mag = mag / RADIX;
            end
            while (mag != 0);
            if (neg)
            begin
                c.ch   = ida_pkg::ASCII_MINUS;
                c.last = 1'b0;
                pending_chars.push_back(c);
            end
            foreach (digits[i])
            begin
                c.ch   = digits[i];
                c.last = (i == digits.size() - 1);
                pending_chars.push_back(c);
            end
            values_seen++;
        endfunction

        function void flag(string what, text_char_t want, logic [7:0] ch, logic last);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("[%0t] %s: expected char %0d last %0b, got char %0d last %0b",
                         $realtime, what, want.ch, want.last, ch, last);
        endfunction

        // Compare one output transaction with the oldest expectation
        function void check_char(logic [7:0] ch, logic last);
            text_char_t want;
            chars_checked++;
            if (pending_chars.size() == 0)
            begin
                want = '0;
                flag("unexpected character", want, ch, last);
                return;
            end
            want = pending_chars.pop_front();
            if (ch !== want.ch)
                flag("wrong character", want, ch, last);
            else if (last !== want.last)
                flag("wrong last flag", want, ch, last);
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [TDW-1:0] s_axis_tdata;   // [VW-1:0] value
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [7:0]     m_axis_tdata;   // [7:0] ascii_char
    logic           m_axis_tlast;   // last

    // Set during the stretch where neither side inserts idle cycles
    bit             calm;
    int             quiet_cycles;
    decimal_text_board board;

    int_to_decimal_ascii #(
        .VALUE_WIDTH (VW)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Present one value; called at a falling edge, returns at a falling edge.
    // tvalid gets at most one assignment per edge, so back-to-back values keep
    // it high across the boundary.
    task automatic send_value(input logic [VW-1:0] v);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDW'(v);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_value(v);
        @(negedge clk);
    endtask

    // Random sign applied to a magnitude
    function automatic logic [VW-1:0] with_sign(logic [VW-1:0] mag);
        return $urandom_range(1) ? (~mag + 1'b1) : mag;
    endfunction

    function automatic logic [VW-1:0] pow10(int n);
        logic [VW-1:0] p;
        p = 1;
        repeat (n) p = p * RADIX;
        return p;
    endfunction

    // Draw a random value, weighted toward digit-count boundaries and extremes
    function automatic logic [VW-1:0] pick_value();
        logic [VW-1:0] lo;
        logic [VW-1:0] hi;
        int            d;
        case ($urandom_range(4))
            0: return $urandom();
            1: return VW'($urandom_range(400)) - VW'(200);
            2:
            begin
                d = $urandom_range(9);
                return with_sign(pow10(d) + VW'($urandom_range(2)) - 1'b1);
            end
            3:
            begin
                d  = $urandom_range(1, 9);
                lo = pow10(d - 1);
                hi = pow10(d) - 1'b1;
                return with_sign(VW'($urandom_range(hi, lo)));
            end
            default:
                if ($urandom_range(1))
                    return {1'b0, {(VW-1){1'b1}}} - VW'($urandom_range(20));
                else
                    return {1'b1, {(VW-1){1'b0}}} + VW'($urandom_range(20));
        endcase
    endfunction

    // Receiver: drop tready at random except during the calm stretch
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Check every output transaction at the rising edge
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_char(m_axis_tdata, m_axis_tlast);

    // Watchdog: count cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d characters outstanding",
                     quiet_cycles, board.pending_chars.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [VW-1:0] directed[$];
        board         = new();
        calm          = 1'b0;
        quiet_cycles  = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero, single digits, digit-count boundaries, both extremes
        // including the most negative value, and alternating bit patterns
        directed = '{
            32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
            32'd100, -32'sd100, 32'd999999999, 32'd1000000000, -32'sd1000000000,
            32'd123456789, -32'sd987654321, 32'h7FFFFFFF, 32'h80000000,
            32'h80000001, 32'h55555555, 32'hAAAAAAAA, 32'hFFFFFFFE, 32'd2147483640
        };
        foreach (directed[i])
            send_value(directed[i]);

        // Random values; a stretch in the middle runs with no idle cycles at all
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= 50 && n < 80);
            send_value(pick_value());
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        // Drain, then hold a while longer to catch stray characters
        while (board.pending_chars.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Converted %0d values (directed edges and random magnitudes), %0d characters",
                 board.values_seen, board.chars_checked);
        $display("checked under random stalls on both sides; %0d mismatches",
                 board.mismatches);
        if (board.mismatches == 0 && board.pending_chars.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
